@@ design/scc_pkg.sv @@
`default_nettype none
package scc_pkg;
    localparam int MAX_NODES = 32;
    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = NW + 1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_FRAME,
        ST_SCAN,
        ST_VISIT,
        ST_CLOSE,
        ST_POP,
        ST_RET,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic next_start;
        logic enter_start;
        logic load_frame;
        logic scan_step;
        logic visit;
        logic pop_one;
        logic close_done;
        logic ret;
        logic emit_clear;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic start_done;
        logic start_visited;
        logic frame_empty;
        logic scan_end;
        logic scan_hit;
        logic scan_visited;
        logic is_root;
        logic pop_last;
        logic emit_last;
    } stat_t;
endpackage
`default_nettype wire

@@ design/scc_if.sv @@
`default_nettype none
interface row_if;
    logic valid;
    logic ready;
    logic [4:0] row_index;
    logic [31:0] row_edges;
    logic last_row;
    modport source (output valid, row_index, row_edges, last_row, input ready);
    modport sink (input valid, row_index, row_edges, last_row, output ready);
endinterface

interface result_if;
    logic valid;
    logic ready;
    logic [4:0] node_index;
    logic [4:0] component_id;
    logic [5:0] component_count;
    logic last_result;
    modport source (output valid, node_index, component_id, component_count,
                    last_result, input ready);
    modport sink (input valid, node_index, component_id, component_count,
                  last_result, output ready);
endinterface
`default_nettype wire

@@ design/scc_datapath.sv @@
`default_nettype none
module scc_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic row_we,
    input  wire logic [4:0] row_idx,
    input  wire logic [31:0] row_bits,
    input  wire logic [scc_pkg::CW-1:0] n_eff,
    input  wire scc_pkg::cmd_t cmd,
    output scc_pkg::stat_t stat,
    output logic [4:0] out_node,
    output logic [4:0] out_comp,
    output logic [5:0] out_count,
    output logic out_last
);
    localparam int N = scc_pkg::MAX_NODES;
    localparam int NW = scc_pkg::NW;
    localparam int CW = scc_pkg::CW;

    logic [31:0] succ_reg [N];
    logic [N-1:0] visited_reg, onstk_reg;
    logic [4:0] disc_reg [N];
    logic [4:0] low_reg [N];
    logic [4:0] label_reg [N];
    logic [NW-1:0] stk_reg [N];
    logic [NW-1:0] fnode_reg [N];
    logic [CW-1:0] fnext_reg [N];
    logic [CW-1:0] stop_reg, ftop_reg, start_reg, scan_reg, emit_reg;
    logic [5:0] visit_cnt_reg, comp_cnt_reg;
    logic [NW-1:0] v_reg;

    logic [NW-1:0] scan_i, top_node, ent_node, parent;
    logic [NW-1:0] start_i, emit_i;
    assign scan_i = scan_reg[NW-1:0];
    assign start_i = start_reg[NW-1:0];
    assign emit_i = emit_reg[NW-1:0];
    assign top_node = stk_reg[NW'(stop_reg - CW'(1))];
    assign parent = fnode_reg[NW'(ftop_reg - CW'(2))];
    assign ent_node = cmd.enter_start ? start_i : scan_i;

    logic edge_bit;
    assign edge_bit = succ_reg[scan_i][v_reg];

    assign stat.start_done = (start_reg >= n_eff);
    assign stat.start_visited = visited_reg[start_i];
    assign stat.frame_empty = (ftop_reg == '0);
    assign stat.scan_end = (scan_reg >= n_eff);
    assign stat.scan_hit = (scan_reg < n_eff) && edge_bit;
    assign stat.scan_visited = visited_reg[scan_i];
    assign stat.is_root = (low_reg[v_reg] == disc_reg[v_reg]);
    assign stat.pop_last = (stop_reg == '0) || (top_node == v_reg);
    assign stat.emit_last = (emit_reg + CW'(1) == n_eff);

    assign out_node = 5'(emit_reg);
    assign out_comp = label_reg[emit_i];
    assign out_count = comp_cnt_reg;
    assign out_last = stat.emit_last;

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            succ_reg[row_idx] <= row_bits;
        end
        if (cmd.enter_start || cmd.visit)
        begin
            disc_reg[ent_node] <= visit_cnt_reg[4:0];
            low_reg[ent_node] <= visit_cnt_reg[4:0];
            if (stop_reg < CW'(N))
            begin
                stk_reg[NW'(stop_reg)] <= ent_node;
            end
            if (ftop_reg < CW'(N))
            begin
                fnode_reg[NW'(ftop_reg)] <= ent_node;
                fnext_reg[NW'(ftop_reg)] <= '0;
            end
        end
        if (cmd.visit)
        begin
            fnext_reg[NW'(ftop_reg - CW'(1))] <= scan_reg + CW'(1);
        end
        if (cmd.scan_step && edge_bit && (scan_reg < n_eff) && visited_reg[scan_i])
        begin
            fnext_reg[NW'(ftop_reg - CW'(1))] <= scan_reg + CW'(1);
            if (onstk_reg[scan_i] && disc_reg[scan_i] < low_reg[v_reg])
            begin
                low_reg[v_reg] <= disc_reg[scan_i];
            end
        end
        if (cmd.pop_one && stop_reg != '0)
        begin
            label_reg[top_node] <= comp_cnt_reg[4:0];
        end
        if (cmd.ret && ftop_reg > CW'(1) && low_reg[v_reg] < low_reg[parent])
        begin
            low_reg[parent] <= low_reg[v_reg];
        end
        if (cmd.load_frame)
        begin
            v_reg <= fnode_reg[NW'(ftop_reg - CW'(1))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            onstk_reg <= '0;
            stop_reg <= '0;
            ftop_reg <= '0;
            start_reg <= '0;
            scan_reg <= '0;
            emit_reg <= '0;
            visit_cnt_reg <= '0;
            comp_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                visited_reg <= '0;
                onstk_reg <= '0;
                stop_reg <= '0;
                ftop_reg <= '0;
                start_reg <= '0;
                visit_cnt_reg <= '0;
                comp_cnt_reg <= '0;
            end
            if (cmd.next_start)
            begin
                start_reg <= start_reg + CW'(1);
            end
            if (cmd.enter_start || cmd.visit)
            begin
                visited_reg[ent_node] <= 1'b1;
                onstk_reg[ent_node] <= 1'b1;
                visit_cnt_reg <= visit_cnt_reg + 6'd1;
                if (stop_reg < CW'(N))
                begin
                    stop_reg <= stop_reg + CW'(1);
                end
                if (ftop_reg < CW'(N))
                begin
                    ftop_reg <= ftop_reg + CW'(1);
                end
            end
            if (cmd.load_frame)
            begin
                scan_reg <= fnext_reg[NW'(ftop_reg - CW'(1))];
            end
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + CW'(1);
            end
            if (cmd.pop_one && stop_reg != '0)
            begin
                onstk_reg[top_node] <= 1'b0;
                stop_reg <= stop_reg - CW'(1);
            end
            if (cmd.close_done)
            begin
                comp_cnt_reg <= comp_cnt_reg + 6'd1;
            end
            if (cmd.ret)
            begin
                ftop_reg <= ftop_reg - CW'(1);
            end
            if (cmd.emit_clear)
            begin
                emit_reg <= '0;
            end
            if (cmd.emit_step)
            begin
                emit_reg <= emit_reg + CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

@@ design/scc_ctrl.sv @@
`default_nettype none
module scc_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic in_last,
    input  wire logic out_ready,
    input  wire scc_pkg::stat_t stat,
    output scc_pkg::cmd_t cmd,
    output logic in_ready,
    output logic out_valid
);
    scc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            scc_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire && in_last)
                begin
                    cmd.clear = 1'b1;
                    state_next = scc_pkg::ST_START;
                end
            end
            scc_pkg::ST_START:
            begin
                if (stat.start_done)
                begin
                    cmd.emit_clear = 1'b1;
                    state_next = scc_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.next_start = 1'b1;
                    if (!stat.start_visited)
                    begin
                        cmd.enter_start = 1'b1;
                        state_next = scc_pkg::ST_FRAME;
                    end
                end
            end
            scc_pkg::ST_FRAME:
            begin
                if (stat.frame_empty)
                begin
                    state_next = scc_pkg::ST_START;
                end
                else
                begin
                    cmd.load_frame = 1'b1;
                    state_next = scc_pkg::ST_SCAN;
                end
            end
            scc_pkg::ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = stat.is_root ? scc_pkg::ST_POP : scc_pkg::ST_RET;
                end
                else if (stat.scan_hit)
                begin
                    state_next = scc_pkg::ST_VISIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            scc_pkg::ST_VISIT:
            begin
                if (stat.scan_visited)
                begin
                    cmd.scan_step = 1'b1;
                    state_next = scc_pkg::ST_CLOSE;
                end
                else
                begin
                    cmd.visit = 1'b1;
                    state_next = scc_pkg::ST_FRAME;
                end
            end
            scc_pkg::ST_CLOSE:
            begin
                state_next = scc_pkg::ST_FRAME;
            end
            scc_pkg::ST_POP:
            begin
                cmd.pop_one = 1'b1;
                if (stat.pop_last)
                begin
                    cmd.close_done = 1'b1;
                    state_next = scc_pkg::ST_RET;
                end
            end
            scc_pkg::ST_RET:
            begin
                cmd.ret = 1'b1;
                state_next = scc_pkg::ST_FRAME;
            end
            scc_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_step = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = scc_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = scc_pkg::ST_LOAD;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ design/strongly_connected_components.sv @@
// channel  dir  fields
// rows     in   row_index, row_edges, last_row
// results  out  node_index, component_id, component_count, last_result
// Rows load one per cycle. A last row runs the search: it tries each start
// node in turn, scans successor slots, descends into each unvisited successor
// found, and per node does a final scan, return and reload, popping the
// component off the stack at a root. Then one word per node in node order.
// No rows are taken during search or output; results stall on ready.
// Reset clears control, stored rows stay undefined.
`default_nettype none
module strongly_connected_components (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [5:0] cfg_data,
    row_if.sink rows,
    result_if.source results
);
    localparam int CW = scc_pkg::CW;
    localparam int MAXN = scc_pkg::MAX_NODES;

    logic [5:0] node_count_reg;
    logic [CW-1:0] n_eff;
    scc_pkg::cmd_t cmd;
    scc_pkg::stat_t stat;
    logic in_fire, in_ready, out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 6'd32;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if ({26'd0, node_count_reg} > MAXN)
        begin
            n_eff = CW'(MAXN);
        end
        else
        begin
            n_eff = CW'(node_count_reg);
        end
    end

    assign rows.ready = in_ready;
    assign in_fire = rows.valid && in_ready;
    assign results.valid = out_valid;

    scc_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_fire(in_fire),
        .in_last(rows.last_row),
        .out_ready(results.ready),
        .stat(stat),
        .cmd(cmd),
        .in_ready(in_ready),
        .out_valid(out_valid)
    );

    scc_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .row_we(in_fire),
        .row_idx(rows.row_index),
        .row_bits(rows.row_edges),
        .n_eff(n_eff),
        .cmd(cmd),
        .stat(stat),
        .out_node(results.node_index),
        .out_comp(results.component_id),
        .out_count(results.component_count),
        .out_last(results.last_result)
    );
endmodule
`default_nettype wire
